>>> sv/cack_pkg.sv
// Shared constants, types and helper functions for the cumulative ack receiver.
// Used by cack_ctrl, cumulative_ack_receiver_unit and the testbench; depends on nothing else.
`default_nettype none

package cack_pkg;

    localparam int SEQ_SPACE = 32768;
    localparam int SEQ_W     = 15;

    localparam int MAP_DEPTH = (SEQ_SPACE < (1 << SEQ_W)) ? SEQ_SPACE : (1 << SEQ_W);
    localparam int ROW_W     = 16;
    localparam int BIT_W     = 4;
    localparam int ROWS      = (MAP_DEPTH + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [SEQ_W:0]    MAP_LIMIT = (SEQ_W + 1)'(MAP_DEPTH);
    localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(ROWS - 1);

    typedef logic [SEQ_W-1:0] seq_t;
    typedef logic [SEQ_W:0]   seq_ext_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [ROW_AW-1:0] row_addr_t;

    typedef struct packed {
        logic start;
        seq_t seq;
        logic drop;
    } cack_req_t;

    typedef struct packed {
        logic idle;
        logic clearing;
        logic ack_fire;
        seq_t ack_value;
    } cack_stat_t;

    function automatic row_addr_t row_of(seq_ext_t x);
        seq_ext_t t;
        t = x >> BIT_W;
        return t[ROW_AW-1:0];
    endfunction

    function automatic logic [BIT_W-1:0] bit_of(seq_ext_t x);
        return x[BIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/cumulative_ack_receiver_unit.sv
// Cumulative ack receiver: one beat in, at most one ack beat out per accepted beat.
// In-order beat: READ fetches the row and MARK sets the bit, then SCAN walks each buffered entry
// up to the one that ends the run (through SLOAD at each 16-entry row boundary), then ACK issues
// the ack, which waits while the output holds an unaccepted beat.
// Other beats are ignored in IDLE or marked out of order through READ and MARK; one beat at a time.
// After reset the bitmap RAM is cleared one row per cycle, all 2048 rows, with s_tready low.
`default_nettype none

module cumulative_ack_receiver_unit
    import cack_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] seq_num, [15] zero
    input  wire logic        s_tuser,   // [0] drop
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [14:0] ack_value, [15] zero
);

    cack_req_t  req;
    cack_stat_t stat;
    logic       out_free;
    logic       m_tvalid_reg, m_tvalid_next;
    seq_t       ack_reg, ack_next;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = stat.idle;
    assign req.start = s_tvalid && s_tready;
    assign req.seq   = s_tdata[SEQ_W-1:0];
    assign req.drop  = s_tuser;

    cack_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .out_free (out_free),
        .stat     (stat)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ack_next      = ack_reg;
        if (stat.ack_fire) begin
            m_tvalid_next = 1'b1;
            ack_next      = stat.ack_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ack_reg <= ack_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, ack_reg};

`ifndef NO_ASSERTIONS
    a_fire_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.ack_fire |-> out_free)
        else $error("ack issued while the output register still holds a beat");

    a_no_accept_clearing: assert property (@(posedge aclk)
        stat.clearing |-> !s_tready)
        else $error("input ready during the bitmap clearing pass");

    a_ack_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.ack_fire |-> (stat.ack_value != '0))
        else $error("cumulative ack of zero issued");

    a_fire_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.ack_fire |=> m_tvalid)
        else $error("ack issued but output not valid in the next cycle");
`endif

endmodule

`default_nettype wire

>>> sv/cack_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Has no dependencies.
`default_nettype none

module cack_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/cack_ctrl.sv
// Sequencer for the received bitmap: clearing pass, marking and the forward scan.
// Depends on cack_pkg and instantiates cack_ram.
`default_nettype none

module cack_ctrl
    import cack_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cack_req_t  req,
    input  wire logic       out_free,
    output cack_stat_t      stat
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SLOAD = 3'd5;
    localparam logic [2:0] ST_ACK   = 3'd6;

    logic [2:0] state_reg, state_next;
    row_addr_t  clr_reg, clr_next;
    seq_t       expected_reg, expected_next;
    seq_ext_t   cur_reg, cur_next;
    seq_ext_t   last_reg, last_next;
    row_t       row_reg, row_next;
    logic       inord_reg, inord_next;

    logic       ram_we;
    row_addr_t  ram_waddr;
    row_t       ram_wdata;
    row_addr_t  ram_raddr;
    row_t       ram_rdata;

    seq_ext_t   req_ext;
    seq_ext_t   nxt;
    row_t       marked;
    logic       req_ok;
    logic       req_inord;

    cack_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        req_ext   = {1'b0, req.seq};
        req_inord = (req.seq == expected_reg);
        req_ok    = (req.seq != '0) && (req_ext < MAP_LIMIT) &&
                    (req_inord ? !req.drop : (req.seq > expected_reg));
        nxt       = last_reg + seq_ext_t'(1);
        marked    = ram_rdata | (row_t'(1) << bit_of(cur_reg));

        state_next    = state_reg;
        clr_next      = clr_reg;
        expected_next = expected_reg;
        cur_next      = cur_reg;
        last_next     = last_reg;
        row_next      = row_reg;
        inord_next    = inord_reg;
        ram_we        = 1'b0;
        ram_waddr     = row_of(cur_reg);
        ram_wdata     = marked;
        ram_raddr     = row_of(cur_reg);

        stat.idle      = (state_reg == ST_IDLE);
        stat.clearing  = (state_reg == ST_CLEAR);
        stat.ack_fire  = 1'b0;
        stat.ack_value = last_reg[SEQ_W-1:0];

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + row_addr_t'(1);
                if (clr_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req.start && req_ok) begin
                    cur_next   = req_ext;
                    inord_next = req_inord;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_MARK;
            end
            ST_MARK: begin
                ram_we     = 1'b1;
                row_next   = marked;
                last_next  = cur_reg;
                state_next = inord_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                ram_raddr = row_of(nxt);
                if (nxt >= MAP_LIMIT) begin
                    state_next = ST_ACK;
                end else if (bit_of(nxt) == '0) begin
                    state_next = ST_SLOAD;
                end else if (row_reg[bit_of(nxt)]) begin
                    last_next = nxt;
                end else begin
                    state_next = ST_ACK;
                end
            end
            ST_SLOAD: begin
                row_next = ram_rdata;
                if (ram_rdata[0]) begin
                    last_next  = nxt;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    stat.ack_fire = 1'b1;
                    expected_next = nxt[SEQ_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            expected_reg <= seq_t'(1);
            inord_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            expected_reg <= expected_next;
            inord_reg    <= inord_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        last_reg <= last_next;
        row_reg  <= row_next;
    end

endmodule

`default_nettype wire

>>> test/tb_cumulative_ack_receiver_unit.sv
// Self-checking testbench for cumulative_ack_receiver_unit: drives sequence-number beats,
// predicts every cumulative ack from its own received map and checks each ack beat in order.
// Depends on cack_pkg and the receiver RTL only.
module tb_cumulative_ack_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cack_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [14:0] seq_num, [15] zero
    logic        s_tuser;    // [0] drop
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;    // [14:0] ack_value, [15] zero

    seq_t ack_queue[$];
    bit   seen_map[MAP_DEPTH];
    seq_t next_expected;
    seq_t last_acked;
    int   useful_beats;
    int   mismatch_count;
    bit   quiet_run;

    cumulative_ack_receiver_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function void track_arrival(seq_t seq, bit drop);
        int last;
        if (seq != '0 && seq >= next_expected) useful_beats++;
        if (seq == '0 || int'(seq) >= SEQ_SPACE) return;
        if (seq == next_expected) begin
            if (drop) return;
            seen_map[seq] = 1'b1;
            last = int'(seq);
            while (last + 1 < MAP_DEPTH && seen_map[last + 1]) last++;
            last_acked = seq_t'(last);
            next_expected = seq_t'(last + 1);
            ack_queue.push_back(last_acked);
        end else if (seq > next_expected) begin
            seen_map[seq] = 1'b1;
        end
    endfunction

    task automatic send_beat(seq_t seq, bit drop);
        while (!quiet_run && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, seq};
        s_tuser  <= drop;
        do @(posedge aclk); while (!s_tready);
        track_arrival(seq, drop);
        @(negedge aclk);
    endtask

    task automatic wait_acks_drained();
        s_tvalid <= 1'b0;
        while (ack_queue.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= quiet_run || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge aclk) begin
        seq_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (ack_queue.size() == 0) begin
                $error("ack_value: no ack expected, actual %0d", m_tdata[14:0]);
                mismatch_count++;
            end else begin
                want = ack_queue.pop_front();
                if (m_tdata[14:0] !== want) begin
                    $error("ack_value: expected %0d, actual %0d", want, m_tdata[14:0]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed();
        int j;
        send_beat('0, 1'b0);
        send_beat('0, 1'b1);
        send_beat(seq_t'(1), 1'b1);
        send_beat(seq_t'(1), 1'b0);
        send_beat(seq_t'(1), 1'b0);
        send_beat(seq_t'(3), 1'b1);
        send_beat(seq_t'(4), 1'b0);
        send_beat(seq_t'(2), 1'b0);
        send_beat(15'h7FFF, 1'b0);
        send_beat(15'h4000, 1'b1);
        send_beat(15'h2AAA, 1'b0);
        // A buffered run that crosses a map row boundary.
        for (j = 7; j <= 17; j++) send_beat(seq_t'(j), 1'b0);
        send_beat(seq_t'(5), 1'b0);
        send_beat(seq_t'(6), 1'b0);
        wait_acks_drained();
    endtask

    task automatic test_in_order_bursts();
        seq_t base;
        seq_t order[6];
        seq_t tmp;
        int   k;
        int   j;
        int   pick;
        int   target;
        int   bursts;
        bit   lost;
        target = useful_beats + 350;
        bursts = 0;
        while (useful_beats < target) begin
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 2))
                    0: begin
                        send_beat('0, 1'($urandom_range(0, 1)));
                    end
                    1: begin
                        if (next_expected > 1)
                            send_beat(seq_t'($urandom_range(1, int'(next_expected) - 1)),
                                      1'($urandom_range(0, 1)));
                    end
                    default: begin
                        send_beat(seq_t'($urandom_range(int'(next_expected) + 20, 32767)),
                                  1'($urandom_range(0, 1)));
                    end
                endcase
            end else begin
                base = next_expected;
                k = $urandom_range(1, 6);
                for (j = 0; j < k; j++) order[j] = base + seq_t'(j);
                for (j = k - 1; j > 0; j--) begin
                    pick = $urandom_range(0, j);
                    tmp = order[j];
                    order[j] = order[pick];
                    order[pick] = tmp;
                end
                lost = $urandom_range(0, 99) < 12;
                for (j = 0; j < k; j++) begin
                    if (order[j] == base) begin
                        send_beat(base, lost);
                    end else begin
                        send_beat(order[j], 1'($urandom_range(0, 1)));
                    end
                end
                if (lost) send_beat(base, 1'b0);
                bursts++;
                if (bursts % 40 == 0) wait_acks_drained();
            end
        end
        wait_acks_drained();
    endtask

    task automatic test_backlog_pause();
        seq_t base;
        int   j;
        base = next_expected;
        for (j = 30; j >= 1; j--) send_beat(base + seq_t'(j), 1'b0);
        wait_acks_drained();
        send_beat(base, 1'b0);
        wait_acks_drained();
    endtask

    task automatic test_quiet_stretch();
        seq_t base;
        int   v;
        quiet_run = 1'b1;
        // Marks near the top of the space, then an unbroken in-order run with no idling.
        for (v = 32767; v > 32767 - 24; v--) begin
            send_beat(seq_t'(v), 1'($urandom_range(0, 1)));
        end
        base = next_expected;
        for (v = 0; v < 24; v++) send_beat(base + seq_t'(v), 1'b0);
        send_beat('0, 1'b0);
        send_beat(seq_t'(1), 1'b0);
        wait_acks_drained();
        quiet_run = 1'b0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        quiet_run      = 1'b0;
        mismatch_count = 0;
        useful_beats   = 0;
        next_expected  = seq_t'(1);
        last_acked     = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_in_order_bursts();
        test_backlog_pause();
        test_quiet_stretch();
        if (mismatch_count == 0 && ack_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
